// File: rtl/cartridge_bank_mapper_with_scanline_irq_macros.svh
// Assertion macros shared by the mapper checker.
`ifndef CARTRIDGE_BANK_MAPPER_WITH_SCANLINE_IRQ_MACROS_SVH
`define CARTRIDGE_BANK_MAPPER_WITH_SCANLINE_IRQ_MACROS_SVH

// Checked only while out of reset.
`define CBM_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define CBM_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/cbm_pkg.sv
// Types and constants for the cartridge bank mapper.
`timescale 1ns / 1ps
package cbm_pkg;

  typedef enum logic [2:0] {
    CmdCpuRead  = 3'd0,
    CmdCpuWrite = 3'd1,
    CmdPpuRead  = 3'd2,
    CmdScanline = 3'd3,
    CmdIrqAck   = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    TgtNone    = 2'd0,
    TgtPrgRom  = 2'd1,
    TgtChrRom  = 2'd2,
    TgtWorkRam = 2'd3
  } tgt_e;

  // CPU address windows, address bits 15..13
  localparam logic [2:0] WinWorkRam = 3'd3;
  localparam logic [2:0] WinBank    = 3'd4;
  localparam logic [2:0] WinMirror  = 3'd5;
  localparam logic [2:0] WinIrqCnt  = 3'd6;
  localparam logic [2:0] WinIrqEn   = 3'd7;

  localparam logic [5:0] MaxPrgBanks   = 6'd32;
  localparam logic [5:0] PrgBanksReset = 6'd32;
  localparam int unsigned WinBytes     = 8192;

  typedef struct packed {
    logic [7:0]      bank_select;
    logic [7:0][7:0] bank_regs;
    logic [5:0]      prg_banks;
    logic            mirror;
    logic            irq_flag;
  } map_state_t;

endpackage

// File: rtl/cbm_wram.sv
// Work RAM: single-port synchronous memory with a held read register.
`timescale 1ns / 1ps
module cbm_wram #(
  parameter int unsigned WORK_RAM_BYTES = 8192
) (
  input  logic        clk_i,
  input  logic        rd_en_i,
  input  logic        wr_en_i,
  input  logic [12:0] addr_i,
  input  logic [7:0]  wdata_i,
  output logic [7:0]  rdata_o
);

  localparam int unsigned AddrW     = $clog2(WORK_RAM_BYTES);
  localparam int unsigned FoldSteps = (cbm_pkg::WinBytes - 1) / WORK_RAM_BYTES;

  logic [7:0]       mem [WORK_RAM_BYTES];
  logic [7:0]       rdata_q;
  logic [13:0]      fold;
  logic [AddrW-1:0] idx;

  // offset modulo the RAM size, by repeated compare-subtract steps
  always_comb begin
    fold = {1'b0, addr_i};
    for (int i = 0; i < FoldSteps; i++) begin
      if (fold >= 14'(WORK_RAM_BYTES)) begin
        fold = fold - 14'(WORK_RAM_BYTES);
      end
    end
    idx = fold[AddrW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[idx] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q <= mem[idx];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/cbm_map.sv
// Address decode and bank mapping for CPU and PPU accesses.
`timescale 1ns / 1ps
module cbm_map (
  input  logic [2:0]          command_i,
  input  logic [15:0]         address_i,
  input  cbm_pkg::map_state_t state_i,
  output cbm_pkg::tgt_e       target_o,
  output logic [18:0]         rom_address_o
);

  logic [5:0] banks;
  logic [5:0] second_last;
  logic [5:0] prg_bank;
  logic [2:0] slot;
  logic [7:0] chr_kb;
  logic       swap;
  logic       in_wram;

  always_comb begin
    if (state_i.prg_banks == '0) begin
      banks = 6'd1;
    end else if (state_i.prg_banks > cbm_pkg::MaxPrgBanks) begin
      banks = cbm_pkg::MaxPrgBanks;
    end else begin
      banks = state_i.prg_banks;
    end
    second_last = 6'(({1'b0, banks} << 1) - 7'd2);
    swap        = state_i.bank_select[6];

    unique case (address_i[15:13])
      cbm_pkg::WinIrqEn:  prg_bank = second_last + 6'd1;
      cbm_pkg::WinIrqCnt: prg_bank = swap ? state_i.bank_regs[6][5:0] : second_last;
      cbm_pkg::WinMirror: prg_bank = state_i.bank_regs[7][5:0];
      cbm_pkg::WinBank:   prg_bank = swap ? second_last : state_i.bank_regs[6][5:0];
      default:            prg_bank = '0;
    endcase

    slot = address_i[12:10] ^ {state_i.bank_select[7], 2'b00};
    if (!slot[2]) begin
      chr_kb = {state_i.bank_regs[{2'b00, slot[1]}][7:1], slot[0]};
    end else begin
      chr_kb = state_i.bank_regs[slot - 3'd2];
    end

    in_wram = (address_i[15:13] == cbm_pkg::WinWorkRam);
  end

  always_comb begin
    unique case (command_i)
      cbm_pkg::CmdCpuRead: begin
        if (in_wram) begin
          target_o      = cbm_pkg::TgtWorkRam;
          rom_address_o = '0;
        end else begin
          target_o      = cbm_pkg::TgtPrgRom;
          rom_address_o = {prg_bank, address_i[12:0]};
        end
      end
      cbm_pkg::CmdCpuWrite: begin
        target_o      = in_wram ? cbm_pkg::TgtWorkRam : cbm_pkg::TgtNone;
        rom_address_o = '0;
      end
      cbm_pkg::CmdPpuRead: begin
        target_o      = cbm_pkg::TgtChrRom;
        rom_address_o = {1'b0, chr_kb, address_i[9:0]};
      end
      default: begin
        target_o      = cbm_pkg::TgtNone;
        rom_address_o = '0;
      end
    endcase
  end

endmodule

// File: rtl/cbm_regs.sv
// Mapper registers: bank select, bank registers, mirroring and IRQ counter.
`timescale 1ns / 1ps
module cbm_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic [2:0]          command_i,
  input  logic [15:0]         address_i,
  input  logic [7:0]          write_data_i,
  input  logic                cfg_we_i,
  input  logic [5:0]          cfg_wdata_i,
  output cbm_pkg::map_state_t state_o
);

  logic [7:0]      bank_select_q, bank_select_d;
  logic [7:0][7:0] bank_regs_q, bank_regs_d;
  logic [5:0]      prg_banks_q;
  logic            mirror_q, mirror_d;
  logic [7:0]      irq_count_q, irq_count_d;
  logic [7:0]      irq_latch_q, irq_latch_d;
  logic            irq_en_q, irq_en_d;
  logic            irq_flag_q, irq_flag_d;
  logic            odd;

  always_comb begin
    bank_select_d = bank_select_q;
    bank_regs_d   = bank_regs_q;
    mirror_d      = mirror_q;
    irq_count_d   = irq_count_q;
    irq_latch_d   = irq_latch_q;
    irq_en_d      = irq_en_q;
    irq_flag_d    = irq_flag_q;
    odd           = address_i[0];

    if (en_i) begin
      unique case (command_i)
        cbm_pkg::CmdCpuWrite: begin
          unique case (address_i[15:13])
            cbm_pkg::WinIrqEn: begin
              irq_en_d = odd;
              if (!odd) begin
                irq_flag_d = 1'b0;
              end
            end
            cbm_pkg::WinIrqCnt: begin
              if (odd) begin
                irq_count_d = '0;
              end else begin
                irq_latch_d = write_data_i;
              end
            end
            cbm_pkg::WinMirror: begin
              if (!odd) begin
                mirror_d = write_data_i[0];
              end
            end
            cbm_pkg::WinBank: begin
              if (odd) begin
                bank_regs_d[bank_select_q[2:0]] = write_data_i;
              end else begin
                bank_select_d = write_data_i;
              end
            end
            default: ;
          endcase
        end
        cbm_pkg::CmdScanline: begin
          irq_count_d = (irq_count_q == '0) ? irq_latch_q : irq_count_q - 8'd1;
          if (irq_count_d == '0 && irq_en_q) begin
            irq_flag_d = 1'b1;
          end
        end
        cbm_pkg::CmdIrqAck: irq_flag_d = 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_select_q <= '0;
      bank_regs_q   <= '0;
      prg_banks_q   <= cbm_pkg::PrgBanksReset;
      mirror_q      <= 1'b0;
      irq_count_q   <= '0;
      irq_latch_q   <= '0;
      irq_en_q      <= 1'b0;
      irq_flag_q    <= 1'b0;
    end else begin
      bank_select_q <= bank_select_d;
      bank_regs_q   <= bank_regs_d;
      mirror_q      <= mirror_d;
      irq_count_q   <= irq_count_d;
      irq_latch_q   <= irq_latch_d;
      irq_en_q      <= irq_en_d;
      irq_flag_q    <= irq_flag_d;
      if (cfg_we_i) begin
        prg_banks_q <= cfg_wdata_i;
      end
    end
  end

  assign state_o.bank_select = bank_select_q;
  assign state_o.bank_regs   = bank_regs_q;
  assign state_o.prg_banks   = prg_banks_q;
  assign state_o.mirror      = mirror_q;
  assign state_o.irq_flag    = irq_flag_q;

endmodule

// File: rtl/cartridge_bank_mapper_with_scanline_irq.sv
// Top level of the cartridge bank mapper with scanline interrupt counter.
// One access is taken per clock and its result is captured in the output register at the
// transfer; a new access is taken whenever the output register is empty or is
// being drained in the same cycle, so throughput is one item per cycle. The work RAM is a
// single-port synchronous memory whose registered read data lines up with that output
// register; it is not cleared after reset, so a read of a byte never written returns
// whatever the memory holds. irq_pending and mirror_horizontal show the state after the
// last accepted access.
`timescale 1ns / 1ps
module cartridge_bank_mapper_with_scanline_irq #(
  parameter int unsigned WORK_RAM_BYTES = 8192
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  command_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  write_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  target_o,
  output logic [18:0] rom_address_o,
  output logic [7:0]  ram_read_data_o,
  output logic        irq_pending_o,
  output logic        mirror_horizontal_o
);

  cbm_pkg::map_state_t state;
  cbm_pkg::tgt_e       target;
  logic [18:0]         rom_address;
  logic [7:0]          ram_rdata;
  logic                accept;
  logic                ram_rd, ram_wr;
  logic                out_valid_q, out_valid_d;
  cbm_pkg::tgt_e       target_q;
  logic [18:0]         rom_address_q;
  logic                ram_rd_q;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign ram_rd     = accept & (command_i == cbm_pkg::CmdCpuRead)
                      & (target == cbm_pkg::TgtWorkRam);
  assign ram_wr     = accept & (command_i == cbm_pkg::CmdCpuWrite)
                      & (target == cbm_pkg::TgtWorkRam);

  cbm_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (accept),
    .command_i    (command_i),
    .address_i    (address_i),
    .write_data_i (write_data_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .state_o      (state)
  );

  cbm_map u_map (
    .command_i     (command_i),
    .address_i     (address_i),
    .state_i       (state),
    .target_o      (target),
    .rom_address_o (rom_address)
  );

  cbm_wram #(
    .WORK_RAM_BYTES (WORK_RAM_BYTES)
  ) u_wram (
    .clk_i   (clk_i),
    .rd_en_i (ram_rd),
    .wr_en_i (ram_wr),
    .addr_i  (address_i[12:0]),
    .wdata_i (write_data_i),
    .rdata_o (ram_rdata)
  );

  assign out_valid_d = accept | in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      target_q      <= target;
      rom_address_q <= rom_address;
      ram_rd_q      <= ram_rd;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign target_o            = target_q;
  assign rom_address_o       = rom_address_q;
  assign ram_read_data_o     = ram_rd_q ? ram_rdata : '0;
  assign irq_pending_o       = state.irq_flag;
  assign mirror_horizontal_o = state.mirror;

endmodule

// File: rtl/cbm_checker.sv
// Port-level checker for the mapper, bound to the top level.
`timescale 1ns / 1ps
`include "cartridge_bank_mapper_with_scanline_irq_macros.svh"
module cbm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [2:0]  command_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  target_o,
  input logic [18:0] rom_address_o,
  input logic [7:0]  ram_read_data_o,
  input logic        irq_pending_o
);

  `CBM_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o, "result dropped while stalled")
  `CBM_ASSERT(a_in_to_out, clk_i, rst_ni, in_valid_i && !in_stall_o |=> out_valid_o, "transfer gave no result")
  `CBM_ASSERT(a_ram_no_rom, clk_i, rst_ni, out_valid_o && target_o == cbm_pkg::TgtWorkRam |-> rom_address_o == '0, "rom address on work RAM access")
  `CBM_ASSERT(a_ramd_gated, clk_i, rst_ni, out_valid_o && target_o != cbm_pkg::TgtWorkRam |-> ram_read_data_o == '0, "RAM data outside work RAM")
  `CBM_ASSERT_ALWAYS(a_ack_clears, clk_i, rst_ni && in_valid_i && !in_stall_o && command_i == cbm_pkg::CmdIrqAck |=> !irq_pending_o, "IRQ not cleared by acknowledge")

endmodule

bind cartridge_bank_mapper_with_scanline_irq cbm_checker u_cbm_checker (.*);

// File: dv/testbench.sv
// Self-checking testbench for the cartridge bank mapper with scanline interrupt counter.
`timescale 1ns / 1ps
module testbench;

  localparam int unsigned RamBytes   = 8192;
  localparam int unsigned CycleLimit = 400000;
  localparam logic [2:0]  CmdSpareLo = 3'd5;
  localparam logic [2:0]  CmdSpareHi = 3'd7;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] addr;
    logic [7:0]  data;
  } access_t;

  typedef struct packed {
    logic [1:0]  target;
    logic [18:0] rom_addr;
    logic [7:0]  ram_data;
    logic        irq;
    logic        mirror;
  } map_result_t;

  typedef enum logic [1:0] {StallNone, StallSparse, StallHeavy, StallToggle} stall_mode_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [5:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  command = '0;
  logic [15:0] address = '0;
  logic [7:0]  write_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  target;
  logic [18:0] rom_address;
  logic [7:0]  ram_read_data;
  logic        irq_pending;
  logic        mirror_horizontal;

  cartridge_bank_mapper_with_scanline_irq #(
    .WORK_RAM_BYTES(RamBytes)
  ) dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_wdata_i        (cfg_wdata),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .command_i          (command),
    .address_i          (address),
    .write_data_i       (write_data),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .target_o           (target),
    .rom_address_o      (rom_address),
    .ram_read_data_o    (ram_read_data),
    .irq_pending_o      (irq_pending),
    .mirror_horizontal_o(mirror_horizontal)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // mapper state as the block should hold it
  logic [5:0]  bank_count = cbm_pkg::PrgBanksReset;
  logic [7:0]  bank_sel = '0;
  logic [7:0]  bank_reg [0:7] = '{default: '0};
  logic        mirror = 1'b0;
  logic [7:0]  irq_count = '0;
  logic [7:0]  irq_latch = '0;
  logic        irq_en = 1'b0;
  logic        irq_flag = 1'b0;
  logic [7:0]  wram [0:RamBytes-1];

  access_t     access_q [$];
  map_result_t due_results [$];
  bit          ram_written [0:RamBytes-1];
  int          written_ofs [$];
  int          n_queued = 0;
  int          errors = 0;
  int          cycles = 0;

  function void map_access(input access_t acc, output map_result_t res);
    logic [2:0]  win;
    logic [6:0]  n;
    logic [5:0]  tail;
    logic [5:0]  bank;
    logic [2:0]  slot;
    logic [7:0]  kb;
    int unsigned ofs;
    win = acc.addr[15:13];
    ofs = acc.addr[12:0] % RamBytes;
    res = '0;
    case (acc.cmd)
      cbm_pkg::CmdCpuRead: begin
        if (win == cbm_pkg::WinWorkRam) begin
          res.target = cbm_pkg::TgtWorkRam;
          res.ram_data = wram[ofs];
        end else begin
          n = {1'b0, bank_count};
          if (n == 0) n = 1;
          if (n > cbm_pkg::MaxPrgBanks) n = cbm_pkg::MaxPrgBanks;
          tail = 6'(2 * n - 2);
          case (win)
            cbm_pkg::WinIrqEn:  bank = tail + 6'd1;
            cbm_pkg::WinIrqCnt: bank = bank_sel[6] ? bank_reg[6][5:0] : tail;
            cbm_pkg::WinMirror: bank = bank_reg[7][5:0];
            cbm_pkg::WinBank:   bank = bank_sel[6] ? tail : bank_reg[6][5:0];
            default:            bank = '0;
          endcase
          res.target = cbm_pkg::TgtPrgRom;
          res.rom_addr = {bank, acc.addr[12:0]};
        end
      end
      cbm_pkg::CmdCpuWrite: begin
        case (win)
          cbm_pkg::WinIrqEn: begin
            if (acc.addr[0]) begin
              irq_en = 1'b1;
            end else begin
              irq_en = 1'b0;
              irq_flag = 1'b0;
            end
          end
          cbm_pkg::WinIrqCnt: begin
            if (acc.addr[0]) irq_count = '0;
            else irq_latch = acc.data;
          end
          cbm_pkg::WinMirror: begin
            if (!acc.addr[0]) mirror = acc.data[0];
          end
          cbm_pkg::WinBank: begin
            if (acc.addr[0]) bank_reg[bank_sel[2:0]] = acc.data;
            else bank_sel = acc.data;
          end
          cbm_pkg::WinWorkRam: begin
            wram[ofs] = acc.data;
            res.target = cbm_pkg::TgtWorkRam;
          end
          default: ;
        endcase
      end
      cbm_pkg::CmdPpuRead: begin
        slot = acc.addr[12:10];
        if (bank_sel[7]) slot[2] = ~slot[2];
        if (!slot[2]) kb = {bank_reg[{2'b00, slot[1]}][7:1], slot[0]};
        else kb = bank_reg[slot - 3'd2];
        res.target = cbm_pkg::TgtChrRom;
        res.rom_addr = {1'b0, kb, acc.addr[9:0]};
      end
      cbm_pkg::CmdScanline: begin
        if (irq_count == 0) irq_count = irq_latch;
        else irq_count = irq_count - 8'd1;
        if (irq_count == 0 && irq_en) irq_flag = 1'b1;
      end
      cbm_pkg::CmdIrqAck: irq_flag = 1'b0;
      default: ;
    endcase
    res.irq = irq_flag;
    res.mirror = mirror;
  endfunction

  // driver: bursts of transfers with random gaps
  access_t cur_acc;
  map_result_t next_result;
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        map_access(cur_acc, next_result);
        due_results.push_back(next_result);
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (access_q.size() > 0) begin
          cur_acc = access_q.pop_front();
          command <= cur_acc.cmd;
          address <= cur_acc.addr;
          write_data <= cur_acc.data;
          in_valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 24);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: receiver stall pattern and result check
  stall_mode_e stall_mode = StallNone;
  int stall_left = 0;
  map_result_t want;

  function void cmp_field(input string name, input logic [31:0] exp_v, input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        stall_left = $urandom_range(16, 160);
      end
      stall_left--;
      case (stall_mode)
        StallNone:   out_stall <= 1'b0;
        StallSparse: out_stall <= ($urandom_range(0, 2) == 0);
        StallHeavy:  out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= ~out_stall;
      endcase
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $display("%0t: result transfer with nothing expected, target %0h rom %0h",
                   $time, target, rom_address);
          errors++;
        end else begin
          want = due_results.pop_front();
          cmp_field("target", want.target, target);
          cmp_field("rom_address", want.rom_addr, rom_address);
          cmp_field("ram_read_data", want.ram_data, ram_read_data);
          cmp_field("irq_pending", want.irq, irq_pending);
          cmp_field("mirror_horizontal", want.mirror, mirror_horizontal);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("FAIL cartridge_bank_mapper_with_scanline_irq");
      $finish;
    end
  end

  task automatic queue_access(input logic [2:0] cmd, input logic [15:0] addr,
                              input logic [7:0] data);
    access_t acc;
    int unsigned ofs;
    acc.cmd = cmd;
    acc.addr = addr;
    acc.data = data;
    if (cmd == cbm_pkg::CmdCpuWrite && addr[15:13] == cbm_pkg::WinWorkRam) begin
      ofs = addr[12:0] % RamBytes;
      if (!ram_written[ofs]) begin
        ram_written[ofs] = 1'b1;
        written_ofs.push_back(ofs);
      end
    end
    if (cmd <= cbm_pkg::CmdIrqAck) n_queued++;
    access_q.push_back(acc);
  endtask

  // random CPU address that never reads a work RAM byte not yet written
  function automatic logic [15:0] readable_cpu_addr();
    logic [15:0] a;
    a = 16'($urandom_range(0, 65535));
    if (a[15:13] == cbm_pkg::WinWorkRam && !ram_written[a[12:0] % RamBytes]) begin
      if (written_ofs.size() > 0)
        a = {cbm_pkg::WinWorkRam,
             13'(written_ofs[$urandom_range(0, written_ofs.size() - 1)])};
      else
        a[15:13] = cbm_pkg::WinBank;
    end
    return a;
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (access_q.size() != 0 || due_results.size() != 0 || in_valid);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_bank_count(input logic [5:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    bank_count = value;
  endtask

  task automatic queue_random(input int count);
    int          goal;
    int          kind;
    int          reps;
    logic [12:0] off;
    logic [15:0] a;
    goal = n_queued + count;
    while (n_queued < goal) begin
      kind = $urandom_range(0, 99);
      off = 13'($urandom_range(0, 8191));
      if (kind < 22) begin
        // bank select then bank data, then a few mapped reads
        queue_access(cbm_pkg::CmdCpuWrite, {cbm_pkg::WinBank, off[12:1], 1'b0},
                     8'($urandom_range(0, 255)));
        queue_access(cbm_pkg::CmdCpuWrite,
                     {cbm_pkg::WinBank, 13'($urandom_range(0, 8191)) | 13'd1},
                     8'($urandom_range(0, 255)));
        reps = $urandom_range(1, 3);
        repeat (reps) begin
          if ($urandom_range(0, 1))
            queue_access(cbm_pkg::CmdCpuRead, readable_cpu_addr(),
                         8'($urandom_range(0, 255)));
          else
            queue_access(cbm_pkg::CmdPpuRead, 16'($urandom_range(0, 65535)),
                         8'($urandom_range(0, 255)));
        end
      end else if (kind < 36) begin
        // interrupt counter sequence
        queue_access(cbm_pkg::CmdCpuWrite, {cbm_pkg::WinIrqCnt, off[12:1], 1'b0},
                     ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                 : 8'($urandom_range(0, 6)));
        if ($urandom_range(0, 1))
          queue_access(cbm_pkg::CmdCpuWrite, {cbm_pkg::WinIrqCnt, off[12:1], 1'b1},
                       8'($urandom_range(0, 255)));
        queue_access(cbm_pkg::CmdCpuWrite,
                     {cbm_pkg::WinIrqEn, off[12:1], ($urandom_range(0, 3) != 0)},
                     8'($urandom_range(0, 255)));
        reps = $urandom_range(1, 10);
        repeat (reps)
          queue_access(cbm_pkg::CmdScanline, 16'($urandom_range(0, 65535)),
                       8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1))
          queue_access(cbm_pkg::CmdIrqAck, 16'($urandom_range(0, 65535)),
                       8'($urandom_range(0, 255)));
      end else if (kind < 46) begin
        a = {cbm_pkg::WinWorkRam, off};
        queue_access(cbm_pkg::CmdCpuWrite, a, 8'($urandom_range(0, 255)));
        queue_access(cbm_pkg::CmdCpuRead, a, 8'($urandom_range(0, 255)));
      end else if (kind < 66) begin
        queue_access(cbm_pkg::CmdCpuRead, readable_cpu_addr(), 8'($urandom_range(0, 255)));
      end else if (kind < 80) begin
        queue_access(cbm_pkg::CmdPpuRead, 16'($urandom_range(0, 65535)),
                     8'($urandom_range(0, 255)));
      end else if (kind < 90) begin
        queue_access(cbm_pkg::CmdCpuWrite, 16'($urandom_range(0, 65535)),
                     8'($urandom_range(0, 255)));
      end else if (kind < 94) begin
        queue_access(cbm_pkg::CmdScanline, 16'($urandom_range(0, 65535)),
                     8'($urandom_range(0, 255)));
      end else if (kind < 97) begin
        queue_access(cbm_pkg::CmdIrqAck, 16'($urandom_range(0, 65535)),
                     8'($urandom_range(0, 255)));
      end else if (kind < 99) begin
        queue_access(cbm_pkg::CmdCpuWrite, {cbm_pkg::WinMirror, off},
                     8'($urandom_range(0, 255)));
      end else begin
        queue_access(3'($urandom_range(CmdSpareLo, CmdSpareHi)),
                     16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  logic [5:0] phase_counts [0:5] = '{6'd1, 6'd0, 6'd63, 6'd17, 6'd2, 6'd32};

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    write_bank_count(cbm_pkg::PrgBanksReset);

    queue_access(cbm_pkg::CmdCpuRead, 16'h0000, 8'h00);
    queue_access(cbm_pkg::CmdCpuRead, 16'hFFFF, 8'hFF);
    queue_access(cbm_pkg::CmdCpuWrite, 16'h6000, 8'hFF);
    queue_access(cbm_pkg::CmdCpuWrite, 16'h7FFF, 8'h00);
    queue_access(cbm_pkg::CmdCpuRead, 16'h7FFF, 8'h00);
    queue_access(cbm_pkg::CmdCpuWrite, 16'h8000, 8'hC6);   // select R6, both swaps on
    queue_access(cbm_pkg::CmdCpuWrite, 16'h8001, 8'hFF);
    queue_access(cbm_pkg::CmdCpuRead, 16'h8000, 8'h00);
    queue_access(cbm_pkg::CmdCpuRead, 16'hDFFF, 8'h00);
    queue_access(cbm_pkg::CmdCpuWrite, 16'h8000, 8'h80);   // select R0, CHR halves swapped
    queue_access(cbm_pkg::CmdCpuWrite, 16'h8001, 8'hFF);
    queue_access(cbm_pkg::CmdPpuRead, 16'h1000, 8'h00);
    queue_access(cbm_pkg::CmdPpuRead, 16'hFFFF, 8'h00);
    queue_access(cbm_pkg::CmdCpuWrite, 16'hA000, 8'h01);
    queue_access(cbm_pkg::CmdCpuWrite, 16'hA001, 8'h00);   // RAM protect, no effect
    queue_access(cbm_pkg::CmdCpuWrite, 16'hC000, 8'h01);
    queue_access(cbm_pkg::CmdCpuWrite, 16'hE001, 8'h00);
    queue_access(cbm_pkg::CmdScanline, 16'h0000, 8'h00);   // reload from latch
    queue_access(cbm_pkg::CmdScanline, 16'h0000, 8'h00);   // reaches zero, irq raised
    queue_access(cbm_pkg::CmdIrqAck, 16'h0000, 8'h00);
    queue_access(cbm_pkg::CmdCpuWrite, 16'hC001, 8'h00);
    queue_access(cbm_pkg::CmdCpuWrite, 16'hE000, 8'h00);
    queue_access(CmdSpareLo, 16'hFFFF, 8'hFF);
    queue_access(CmdSpareHi, 16'h8001, 8'hFF);
    queue_access(cbm_pkg::CmdCpuWrite, 16'h0000, 8'hFF);   // below work RAM, ignored
    wait_idle();

    foreach (phase_counts[i]) begin
      write_bank_count(phase_counts[i]);
      queue_random(110);
      wait_idle();
    end

    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("PASS cartridge_bank_mapper_with_scanline_irq");
    end else begin
      $display("FAIL cartridge_bank_mapper_with_scanline_irq");
    end
    $finish;
  end

endmodule

// File: cartridge_bank_mapper_with_scanline_irq.f
+incdir+rtl
rtl/cbm_pkg.sv
rtl/cbm_wram.sv
rtl/cbm_map.sv
rtl/cbm_regs.sv
rtl/cartridge_bank_mapper_with_scanline_irq.sv
rtl/cbm_checker.sv
dv/testbench.sv
